### src/sttbs_pkg.sv
// ----------------------------------------------------------------------------
// sttbs_pkg: shared definitions for the sine test tone byte stream
// Sizes, register indexes, reset values, fixed-point constants and the
// types that travel between the front queue, the back end and the sine unit.
// ----------------------------------------------------------------------------
package sttbs_pkg;

    // Structural sizes
    localparam int TABLE_BITS   = 10;
    localparam int MAX_CHANNELS = 8;
    localparam int LOOP_BITS    = 24;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

    // Register field widths
    localparam int RATE_W  = 18;
    localparam int FREQ_W  = 17;
    localparam int RECIP_W = 32;
    localparam int CC_W    = 4;
    localparam int FMT_W   = 2;
    localparam int LEN_W   = 24;

    // Phase modulo unit
    localparam int SUM_W     = RATE_W + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Sine address fold
    localparam int T_SHIFT = 32 - TABLE_BITS;
    localparam int Q_W     = TABLE_BITS - 1;
    localparam logic [Q_W-1:0] QSIZE = Q_W'(1 << (TABLE_BITS - 2));

    // Front queue
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_RECIP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH   = 3'd6;

    // Reset values of the registers
    localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE   = 18'd48000;
    localparam logic [FREQ_W-1:0]  RST_TONE_FREQ     = 17'd800;
    localparam logic [RECIP_W-1:0] RST_RATE_RECIP    = 32'd89478;
    localparam logic [CC_W-1:0]    RST_CHANNEL_COUNT = 4'd2;
    localparam logic [FMT_W-1:0]   RST_SAMPLE_FORMAT = 2'd3;
    localparam logic               RST_BIG_ENDIAN    = 1'b0;
    localparam logic [LEN_W-1:0]   RST_LOOP_LENGTH   = 24'd153600;

    // Sample format codes: bit 1 selects 16-bit, bit 0 selects signed
    localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_S8  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_U16 = 2'd2;
    localparam logic [FMT_W-1:0] FMT_S16 = 2'd3;

    // Q30 fixed point
    localparam int Q_FRAC = 30;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] COEF_1  = 31'd1686629713;
    localparam logic [30:0] COEF_3  = 31'd693598668;
    localparam logic [30:0] COEF_5  = 31'd85569305;
    localparam logic [30:0] COEF_7  = 31'd5026985;
    localparam logic [30:0] COEF_9  = 31'd172272;

    localparam logic [15:0] SCALE_U8  = 16'd255;
    localparam logic [15:0] SCALE_S8  = 16'd127;
    localparam logic [15:0] SCALE_U16 = 16'd65535;
    localparam logic [15:0] SCALE_S16 = 16'd32767;

    // Configuration bundle
    typedef struct packed {
        logic [RATE_W-1:0]  sample_rate;
        logic [FREQ_W-1:0]  tone_freq;
        logic [RECIP_W-1:0] rate_recip;
        logic [CC_W-1:0]    channel_count;
        logic [FMT_W-1:0]   sample_format;
        logic               big_endian;
        logic [LEN_W-1:0]   loop_length;
    } cfg_t;

    // One queued request
    typedef struct packed {
        logic restart;
        logic last;
    } item_t;

    // Sine unit status toward the back end
    typedef struct packed {
        logic busy;
        logic done;
    } sine_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SINE,
        BK_EMIT,
        BK_MOD
    } back_state_t;

    typedef enum logic [3:0] {
        SN_IDLE,
        SN_ADDR,
        SN_FOLD,
        SN_SQUARE,
        SN_T2,
        SN_PMUL,
        SN_PSUB,
        SN_TMUL,
        SN_CLAMP,
        SN_BIAS,
        SN_FMUL,
        SN_DONE
    } sine_state_t;

    // Horner coefficients after the innermost one, from the inside out.
    function automatic logic [30:0] poly_coef(input logic [1:0] k);
        logic [30:0] c;
        case (k)
            2'd0:    c = COEF_7;
            2'd1:    c = COEF_5;
            2'd2:    c = COEF_3;
            default: c = COEF_1;
        endcase
        return c;
    endfunction

    // Output scale factor for each sample format.
    function automatic logic [15:0] fmt_scale(input logic [FMT_W-1:0] fmt);
        logic [15:0] s;
        case (fmt)
            FMT_U8:  s = SCALE_U8;
            FMT_S8:  s = SCALE_S8;
            FMT_U16: s = SCALE_U16;
            default: s = SCALE_S16;
        endcase
        return s;
    endfunction

endpackage

### src/sttbs_front.sv
// ----------------------------------------------------------------------------
// sttbs_front: input stage and request queue
// Accepts stream requests, splits them into restart and end-of-request
// flags and holds them in a short queue that the back end drains.
// ----------------------------------------------------------------------------
module sttbs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sttbs_pkg::item_t    in_item,
    input  logic                pop,
    output logic                q_valid,
    output sttbs_pkg::item_t    q_item
);
    import sttbs_pkg::*;

    item_t             mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              push;

    // Handshake status of the queue.
    assign in_ready = (cnt_reg != QCNT_W'(Q_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### src/sttbs_sine.sv
// ----------------------------------------------------------------------------
// sttbs_sine: sine sample generator
// Scales the phase to a table address, evaluates the quarter-wave
// polynomial in Q30 and formats the sample, all on one shared multiplier.
// ----------------------------------------------------------------------------
module sttbs_sine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sttbs_pkg::RATE_W-1:0] phase,
    input  sttbs_pkg::cfg_t              cfg,
    output sttbs_pkg::sine_status_t      status,
    output logic [15:0]                  sample
);
    import sttbs_pkg::*;

    sine_state_t       state_reg;
    sine_state_t       state_next;
    logic [RATE_W-1:0] ph_reg;
    logic [63:0]       prod_reg;
    logic [30:0]       t_reg;
    logic [30:0]       t2_reg;
    logic [30:0]       h_reg;
    logic [30:0]       m_reg;
    logic [31:0]       op_reg;
    logic              neg_reg;
    logic [1:0]        k_reg;

    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [TABLE_BITS-1:0] addr;
    logic [1:0]            quad;
    logic [Q_W-1:0]        quad_pos;
    logic [Q_W-1:0]        q;
    logic [31:0]           poly_out;
    logic [30:0]           m_clamped;
    logic [31:0]           biased;
    logic [15:0]           mag16;

    // Address fold into the first quadrant.
    always_comb
    begin
        addr     = prod_reg[T_SHIFT +: TABLE_BITS];
        quad     = addr[TABLE_BITS-1 -: 2];
        quad_pos = {1'b0, addr[TABLE_BITS-3:0]};
        q        = quad[0] ? (QSIZE - quad_pos) : quad_pos;
    end

    // Clamp, bias and final scaling of the magnitude.
    always_comb
    begin
        poly_out  = prod_reg[Q_FRAC +: 32];
        m_clamped = (poly_out > {1'b0, Q30_ONE}) ? Q30_ONE : poly_out[30:0];
        biased    = neg_reg ? ({1'b0, Q30_ONE} - {1'b0, m_reg})
                            : ({1'b0, Q30_ONE} + {1'b0, m_reg});
        mag16     = cfg.sample_format[0] ? prod_reg[Q_FRAC +: 16] : prod_reg[Q_FRAC + 1 +: 16];
        if (cfg.sample_format[0] && neg_reg)
        begin
            if (cfg.sample_format[1])
            begin
                sample = 16'h0000 - mag16;
            end
            else
            begin
                sample = {8'h00, 8'h00 - mag16[7:0]};
            end
        end
        else
        begin
            sample = mag16;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            SN_ADDR:
            begin
                mul_a = 32'(ph_reg);
                mul_b = cfg.rate_recip;
            end
            SN_SQUARE:
            begin
                mul_a = {1'b0, t_reg};
                mul_b = {1'b0, t_reg};
            end
            SN_PMUL:
            begin
                mul_a = {1'b0, t2_reg};
                mul_b = {1'b0, h_reg};
            end
            SN_TMUL:
            begin
                mul_a = {1'b0, t_reg};
                mul_b = {1'b0, h_reg};
            end
            SN_FMUL:
            begin
                mul_a = op_reg;
                mul_b = 32'(fmt_scale(cfg.sample_format));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SN_IDLE:   if (start) state_next = SN_ADDR;
            SN_ADDR:   state_next = SN_FOLD;
            SN_FOLD:   state_next = SN_SQUARE;
            SN_SQUARE: state_next = SN_T2;
            SN_T2:     state_next = SN_PMUL;
            SN_PMUL:   state_next = SN_PSUB;
            SN_PSUB:   state_next = (k_reg == 2'd3) ? SN_TMUL : SN_PMUL;
            SN_TMUL:   state_next = SN_CLAMP;
            SN_CLAMP:  state_next = SN_BIAS;
            SN_BIAS:   state_next = SN_FMUL;
            SN_FMUL:   state_next = SN_DONE;
            SN_DONE:   state_next = SN_IDLE;
            default:   state_next = SN_IDLE;
        endcase
    end

    assign status.busy = (state_reg != SN_IDLE);
    assign status.done = (state_reg == SN_DONE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SN_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            SN_IDLE:
            begin
                if (start)
                begin
                    ph_reg <= phase;
                end
            end
            SN_ADDR, SN_SQUARE, SN_PMUL, SN_TMUL, SN_FMUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            SN_FOLD:
            begin
                t_reg   <= 31'(q) << T_SHIFT;
                neg_reg <= quad[1];
            end
            SN_T2:
            begin
                t2_reg <= prod_reg[Q_FRAC +: 31];
                h_reg  <= COEF_9;
                k_reg  <= 2'd0;
            end
            SN_PSUB:
            begin
                h_reg <= poly_coef(k_reg) - prod_reg[Q_FRAC +: 31];
                k_reg <= k_reg + 2'd1;
            end
            SN_CLAMP:
            begin
                m_reg <= m_clamped;
            end
            SN_BIAS:
            begin
                op_reg <= cfg.sample_format[0] ? {1'b0, m_reg} : biased;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### src/sttbs_back.sv
// ----------------------------------------------------------------------------
// sttbs_back: byte sequencer
// Drains the request queue, keeps the loop position, channel and byte
// counters and the phase, triggers the sine unit at each frame start and
// loads the output register. The phase wrap uses a restoring modulo.
// ----------------------------------------------------------------------------
module sttbs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sttbs_pkg::cfg_t  cfg,
    input  logic             q_valid,
    input  sttbs_pkg::item_t q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_loop_end,
    output logic             out_req_end
);
    import sttbs_pkg::*;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [LOOP_BITS-1:0] pos_reg;
    logic [RATE_W-1:0]    ph_reg;
    logic [CH_W-1:0]      ch_reg;
    logic                 bis_reg;
    logic [15:0]          held_reg;
    logic                 req_last_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_loop_end_reg;
    logic                 out_req_end_reg;
    logic [SUM_W-1:0]     dvd_reg;
    logic [RATE_W-1:0]    div_reg;
    logic [RATE_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    sine_status_t         sine_st;
    logic [15:0]          sine_sample;
    logic                 sine_start;
    logic [RATE_W-1:0]    ph_eff;
    logic                 frame_start;
    logic                 slot_free;
    logic                 out_load;
    logic                 wide;
    logic                 hi_byte;
    logic [7:0]           byte_sel;
    logic [LOOP_BITS-1:0] pos_inc;
    logic                 last;
    logic [CNT_W-1:0]     chans;
    logic [CNT_W-1:0]     ch_inc;
    logic                 second_byte;
    logic                 chan_wrap;
    logic [SUM_W-1:0]     sum;
    logic                 sum_fits;
    logic                 rate_zero;
    logic [SUM_W-1:0]     rs;
    logic                 rs_ge;
    logic [RATE_W-1:0]    rem_new;

    sttbs_sine u_sine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sine_start),
        .phase  (ph_eff),
        .cfg    (cfg),
        .status (sine_st),
        .sample (sine_sample)
    );

    // Restart handling and frame start detection for the head request.
    assign ph_eff      = q_item.restart ? '0 : ph_reg;
    assign frame_start = q_item.restart || (ch_reg == '0 && !bis_reg);

    // Byte selection and loop end.
    always_comb
    begin
        wide     = cfg.sample_format[1];
        hi_byte  = wide && (bis_reg ^ cfg.big_endian);
        byte_sel = hi_byte ? held_reg[15:8] : held_reg[7:0];
        pos_inc  = pos_reg + LOOP_BITS'(1);
        last     = (pos_inc == LOOP_BITS'(cfg.loop_length));
    end

    // Channel count clamp and channel advance.
    always_comb
    begin
        if (cfg.channel_count == '0)
        begin
            chans = CNT_W'(1);
        end
        else if (int'(cfg.channel_count) > MAX_CHANNELS)
        begin
            chans = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            chans = CNT_W'(cfg.channel_count);
        end
        ch_inc      = CNT_W'(ch_reg) + CNT_W'(1);
        second_byte = wide && !bis_reg;
        chan_wrap   = !second_byte && (ch_inc >= chans);
    end

    // Phase advance: a single compare covers the common case.
    always_comb
    begin
        sum       = SUM_W'(ph_reg) + SUM_W'(cfg.tone_freq);
        rate_zero = (cfg.sample_rate == '0);
        sum_fits  = (sum < SUM_W'(cfg.sample_rate));
    end

    // One restoring modulo step.
    always_comb
    begin
        rs      = {rem_reg, dvd_reg[SUM_W-1]};
        rs_ge   = (rs >= SUM_W'(div_reg));
        rem_new = rs_ge ? RATE_W'(rs - SUM_W'(div_reg)) : rs[RATE_W-1:0];
    end

    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        sine_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (frame_start)
                    begin
                        sine_start = 1'b1;
                        state_next = BK_SINE;
                    end
                    else
                    begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_SINE:
            begin
                if (sine_st.done)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (!last && chan_wrap && !rate_zero && !sum_fits)
                    begin
                        state_next = BK_MOD;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_MOD:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            pos_reg   <= '0;
            ph_reg    <= '0;
            ch_reg    <= '0;
            bis_reg   <= 1'b0;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && q_item.restart)
            begin
                pos_reg <= '0;
                ph_reg  <= '0;
                ch_reg  <= '0;
                bis_reg <= 1'b0;
            end
            if (state_reg == BK_SINE && sine_st.done)
            begin
                held_reg <= sine_sample;
            end
            if (out_load)
            begin
                if (last)
                begin
                    pos_reg <= '0;
                    ph_reg  <= '0;
                    ch_reg  <= '0;
                    bis_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_inc;
                    bis_reg <= second_byte;
                    if (!second_byte)
                    begin
                        if (chan_wrap)
                        begin
                            ch_reg <= '0;
                            if (rate_zero)
                            begin
                                ph_reg <= '0;
                            end
                            else if (sum_fits)
                            begin
                                ph_reg <= sum[RATE_W-1:0];
                            end
                        end
                        else
                        begin
                            ch_reg <= CH_W'(ch_inc);
                        end
                    end
                end
            end
            if (state_reg == BK_MOD && div_cnt_reg == '0)
            begin
                ph_reg <= rem_new;
            end
        end
    end

    // Modulo unit registers; the operands are captured so that the
    // remainder does not depend on later register writes.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dvd_reg     <= sum;
            div_reg     <= cfg.sample_rate;
            rem_reg     <= '0;
            div_cnt_reg <= DIV_CNT_W'(SUM_W - 1);
        end
        else if (state_reg == BK_MOD)
        begin
            dvd_reg     <= dvd_reg << 1;
            rem_reg     <= rem_new;
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // Request flag of the item in flight.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_last_reg <= q_item.last;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg     <= byte_sel;
            out_loop_end_reg <= last;
            out_req_end_reg  <= req_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_loop_end = out_loop_end_reg;
    assign out_req_end  = out_req_end_reg;

    // The sine unit only finishes while the sequencer waits for it.
    a_done_in_sine: assert property (@(posedge clk) disable iff (!rst_n)
        sine_st.done |-> state_reg == BK_SINE)
        else $error("sine unit finished outside of the wait state");

    // A new request is taken only with the sine unit idle.
    a_pop_sine_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !sine_st.busy)
        else $error("request taken while the sine unit is busy");

    // The modulo runs with a nonzero divisor and a reduced remainder.
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_MOD |-> (div_reg != '0) && (rem_reg < div_reg))
        else $error("phase modulo out of range");

    // A loaded byte is offered in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded byte not offered");

endmodule

### src/sine_test_tone_byte_stream_top.sv
// ----------------------------------------------------------------------------
// sine_test_tone_byte_stream_top: looping sine test tone as a byte stream
// Inside a frame each request is popped and its byte loaded into the output
// register; at a frame start the shared multiplier first evaluates the sine.
// A request is taken only once the previous byte is loaded; a phase wrap past
// the sample rate first runs the bit-serial modulo at the frame end.
// Reset: counters, phase and held sample clear; registers take defaults.
// ----------------------------------------------------------------------------
module sine_test_tone_byte_stream_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [0] restart, [7:1] zero
    input  logic                            s_axis_tlast,  // last_of_request
    // Byte stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] data_byte
    output logic                            m_axis_tuser,  // [0] loop_end
    output logic                            m_axis_tlast,  // request_end
    // Register writes
    input  logic                            cfg_we,
    input  logic [sttbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sttbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sttbs_pkg::*;

    cfg_t  cfg_reg;
    item_t in_item;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    // Register bank.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_rate   <= RST_SAMPLE_RATE;
            cfg_reg.tone_freq     <= RST_TONE_FREQ;
            cfg_reg.rate_recip    <= RST_RATE_RECIP;
            cfg_reg.channel_count <= RST_CHANNEL_COUNT;
            cfg_reg.sample_format <= RST_SAMPLE_FORMAT;
            cfg_reg.big_endian    <= RST_BIG_ENDIAN;
            cfg_reg.loop_length   <= RST_LOOP_LENGTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_RATE:   cfg_reg.sample_rate   <= cfg_data[RATE_W-1:0];
                REG_TONE_FREQ:     cfg_reg.tone_freq     <= cfg_data[FREQ_W-1:0];
                REG_RATE_RECIP:    cfg_reg.rate_recip    <= cfg_data[RECIP_W-1:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[CC_W-1:0];
                REG_SAMPLE_FORMAT: cfg_reg.sample_format <= cfg_data[FMT_W-1:0];
                REG_BIG_ENDIAN:    cfg_reg.big_endian    <= cfg_data[0];
                REG_LOOP_LENGTH:   cfg_reg.loop_length   <= cfg_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Request fields.
    assign in_item.restart = s_axis_tdata[0];
    assign in_item.last    = s_axis_tlast;

    sttbs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    sttbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (m_axis_tdata),
        .out_loop_end (m_axis_tuser),
        .out_req_end  (m_axis_tlast)
    );

endmodule

### dv/sine_test_tone_byte_stream_top_tb.sv
// ----------------------------------------------------------------------------
// sine_test_tone_byte_stream_top_tb: self-checking bench for the tone streamer
// A queue-fed driver offers byte requests. A clocked predictor mirrors the
// phase counter, the sine scaling, the sample formats, the channel repeat and
// the loop counter, and a monitor compares every emitted byte with it. The
// registers are rewritten between phases while the block is idle. The run
// covers directed corner settings, then random settings under three idling
// mixes and one long hold-off on the byte side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_test_tone_byte_stream_top_tb;

    import sttbs_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int PRINT_CAP     = 100;

    // Q30 quarter-wave polynomial terms, innermost last.
    localparam logic [63:0] SINE_ONE = 64'd1073741824;
    localparam logic [63:0] POLY_1   = 64'd1686629713;
    localparam logic [63:0] POLY_3   = 64'd693598668;
    localparam logic [63:0] POLY_5   = 64'd85569305;
    localparam logic [63:0] POLY_7   = 64'd5026985;
    localparam logic [63:0] POLY_9   = 64'd172272;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       loop_end;
        logic       request_end;
    } tone_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'd0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copies used by the predictor.
    logic [RATE_W-1:0]  cur_rate  = RST_SAMPLE_RATE;
    logic [FREQ_W-1:0]  cur_freq  = RST_TONE_FREQ;
    logic [RECIP_W-1:0] cur_recip = RST_RATE_RECIP;
    logic [CC_W-1:0]    cur_chans = RST_CHANNEL_COUNT;
    logic [FMT_W-1:0]   cur_fmt   = RST_SAMPLE_FORMAT;
    logic               cur_big   = RST_BIG_ENDIAN;
    logic [LEN_W-1:0]   cur_len   = RST_LOOP_LENGTH;

    // Predicted stream position.
    logic [LOOP_BITS-1:0] tone_pos   = '0;
    logic [RATE_W-1:0]    tone_phase = '0;
    int unsigned          tone_chan  = 0;
    logic                 tone_hi    = 1'b0;
    logic [15:0]          tone_held  = 16'd0;

    item_t      pending_requests[$];
    tone_byte_t expected_bytes[$];
    item_t      next_req;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int mismatch_count = 0;
    int bytes_seen    = 0;

    sine_test_tone_byte_stream_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Random gap decision for either side of the stream.
    function automatic logic idle_roll(input int pct);
        return (pct != 0) && ($urandom_range(99) < pct);
    endfunction

    // sin(pi/2 * t) for t in Q30 over one quarter wave, result in Q30.
    function automatic logic [63:0] quarter_wave(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] h;
        t2 = (t * t) >> 30;
        h = POLY_7 - ((t2 * POLY_9) >> 30);
        h = POLY_5 - ((t2 * h) >> 30);
        h = POLY_3 - ((t2 * h) >> 30);
        h = POLY_1 - ((t2 * h) >> 30);
        h = (t * h) >> 30;
        return (h > SINE_ONE) ? SINE_ONE : h;
    endfunction

    // Formatted sine sample for the current phase and registers.
    function automatic logic [15:0] tone_sample();
        logic [63:0]           prod;
        logic [TABLE_BITS-1:0] addr;
        logic [63:0]           quad_pos;
        logic [63:0]           fold;
        logic [63:0]           mag;
        logic [63:0]           biased;
        logic [63:0]           v;
        logic                  neg;
        prod     = 64'(tone_phase) * 64'(cur_recip);
        addr     = TABLE_BITS'(prod >> (32 - TABLE_BITS));
        quad_pos = 64'(addr[TABLE_BITS-3:0]);
        fold     = addr[TABLE_BITS-2] ? ((64'd1 << (TABLE_BITS - 2)) - quad_pos) : quad_pos;
        mag      = quarter_wave(fold << (32 - TABLE_BITS));
        neg      = addr[TABLE_BITS-1];
        biased   = neg ? (SINE_ONE - mag) : (SINE_ONE + mag);
        case (cur_fmt)
            FMT_U8:
                v = (biased * 64'd255) >> 31;
            FMT_S8:
            begin
                v = (mag * 64'd127) >> 30;
                if (neg)
                    v = (64'd0 - v) & 64'hFF;
            end
            FMT_U16:
                v = (biased * 64'd65535) >> 31;
            default:
            begin
                v = (mag * 64'd32767) >> 30;
                if (neg)
                    v = (64'd0 - v) & 64'hFFFF;
            end
        endcase
        return v[15:0];
    endfunction

    // Advance the predicted stream by one requested byte.
    task automatic predict_byte(input logic restart, input logic req_end);
        tone_byte_t           exp_byte;
        logic                 wide;
        int unsigned          chans;
        logic [LOOP_BITS-1:0] next_pos;
        logic                 at_end;
        wide  = cur_fmt[1];
        chans = (cur_chans == 0) ? 1 :
                (cur_chans > MAX_CHANNELS) ? MAX_CHANNELS : int'(cur_chans);
        if (restart)
        begin
            tone_pos   = '0;
            tone_phase = '0;
            tone_chan  = 0;
            tone_hi    = 1'b0;
        end
        // A new sample is taken only at the first byte of a frame.
        if (tone_chan == 0 && !tone_hi)
            tone_held = tone_sample();
        if (wide && (tone_hi != cur_big))
            exp_byte.data_byte = tone_held[15:8];
        else
            exp_byte.data_byte = tone_held[7:0];
        next_pos = tone_pos + 1'b1;
        at_end = (next_pos == LOOP_BITS'(cur_len));
        exp_byte.loop_end    = at_end;
        exp_byte.request_end = req_end;
        expected_bytes.push_back(exp_byte);
        if (at_end)
        begin
            tone_pos   = '0;
            tone_phase = '0;
            tone_chan  = 0;
            tone_hi    = 1'b0;
        end
        else
        begin
            tone_pos = next_pos;
            if (wide && !tone_hi)
                tone_hi = 1'b1;
            else
            begin
                tone_hi = 1'b0;
                tone_chan++;
                if (tone_chan >= chans)
                begin
                    tone_chan  = 0;
                    tone_phase = (cur_rate == 0) ? '0 :
                        RATE_W'((64'(tone_phase) + 64'(cur_freq)) % 64'(cur_rate));
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("byte %0d: %s got %0h want %0h", bytes_seen, what, got, want);
        mismatch_count++;
    endtask

    // Request driver: takes pending requests and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'd0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_byte(s_axis_tdata[0], s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_requests.size() != 0 && !idle_roll(send_idle_pct))
                begin
                    next_req = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, next_req.restart};
                    s_axis_tlast  <= next_req.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor: checks each accepted byte and paces the ready line.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("byte with nothing pending", m_axis_tdata, 8'd0);
                end
                else
                begin
                    if (m_axis_tdata != expected_bytes[0].data_byte)
                        report_mismatch("data_byte", m_axis_tdata,
                                        expected_bytes[0].data_byte);
                    if (m_axis_tuser != expected_bytes[0].loop_end)
                        report_mismatch("loop_end", 8'(m_axis_tuser),
                                        8'(expected_bytes[0].loop_end));
                    if (m_axis_tlast != expected_bytes[0].request_end)
                        report_mismatch("request_end", 8'(m_axis_tlast),
                                        8'(expected_bytes[0].request_end));
                    void'(expected_bytes.pop_front());
                end
                bytes_seen++;
            end
            // A long hold-off lets the block fill up and stall its input.
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= !idle_roll(recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles where neither side moves a request or a byte.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("sine_test_tone_byte_stream_top_tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_request(input logic restart, input logic last);
        item_t req;
        req.restart = restart;
        req.last    = last;
        pending_requests.push_back(req);
    endtask

    // Waits until every request is taken and every byte is back, then lets
    // the sine and modulo units finish any work behind the last byte.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_SAMPLE_RATE:   cur_rate  = value[RATE_W-1:0];
            REG_TONE_FREQ:     cur_freq  = value[FREQ_W-1:0];
            REG_RATE_RECIP:    cur_recip = value[RECIP_W-1:0];
            REG_CHANNEL_COUNT: cur_chans = value[CC_W-1:0];
            REG_SAMPLE_FORMAT: cur_fmt   = value[FMT_W-1:0];
            REG_BIG_ENDIAN:    cur_big   = value[0];
            default:           cur_len   = value[LEN_W-1:0];
        endcase
    endtask

    // Rewrites every register once the block has gone idle.
    task automatic apply_setting(input logic [31:0] rate, input logic [31:0] freq,
                                 input logic [31:0] recip, input logic [31:0] chans,
                                 input logic [FMT_W-1:0] fmt, input logic big,
                                 input logic [31:0] len);
        wait_idle();
        write_reg(REG_SAMPLE_RATE, rate);
        write_reg(REG_TONE_FREQ, freq);
        write_reg(REG_RATE_RECIP, recip);
        write_reg(REG_CHANNEL_COUNT, chans);
        write_reg(REG_SAMPLE_FORMAT, 32'(fmt));
        write_reg(REG_BIG_ENDIAN, 32'(big));
        write_reg(REG_LOOP_LENGTH, len);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random register set: mostly a consistent tone with short loops so that
    // loop ends come often, with the odd corner value mixed in.
    task automatic random_setting();
        logic [31:0]      rate;
        logic [31:0]      freq;
        logic [31:0]      recip;
        logic [31:0]      chans;
        logic [31:0]      frame;
        logic [31:0]      len;
        logic [FMT_W-1:0] fmt;
        int               pick;
        pick = $urandom_range(15);
        if (pick == 0)
            rate = 0;
        else if (pick == 1)
            rate = 192000;
        else if (pick == 2)
            rate = $urandom_range(1, 16);
        else
            rate = $urandom_range(8000, 192000);
        pick = $urandom_range(9);
        if (pick == 0)
            freq = 0;
        else if (pick == 1)
            freq = 96000;
        else
            freq = $urandom_range(1, 96000);
        if (rate == 0 || $urandom_range(4) == 0)
            recip = $urandom();
        else
            recip = 32'(((64'd1 << 32) + 64'(rate / 2)) / 64'(rate));
        chans = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        fmt   = FMT_W'($urandom_range(3));
        frame = ((chans == 0) ? 1 : (chans > MAX_CHANNELS) ? MAX_CHANNELS : chans)
                * (fmt[1] ? 2 : 1);
        pick = $urandom_range(9);
        if (pick == 0)
            len = $urandom_range(1, 300);
        else if (pick == 1)
            len = $urandom_range(1) ? 32'hFF_FFFF : 32'd0;
        else
            len = frame * $urandom_range(1, 30);
        apply_setting(rate, freq, recip, chans, fmt, 1'($urandom_range(1)), len);
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 88;

        // Reset defaults; the run stops in the middle of a frame.
        push_request(1'b1, 1'b0);
        push_request(1'b0, 1'b1);
        push_request(1'b0, 1'b0);
        push_request(1'b0, 1'b1);
        push_request(1'b1, 1'b1);
        push_request(1'b0, 1'b0);

        // Largest values, a reciprocal that does not match the rate and a
        // channel count above the supported maximum, changed mid-frame.
        apply_setting(192000, 96000, 32'hFFFF_FFFF, 15, FMT_S8, 1'b1, 32'hFF_FFFF);
        repeat (4) push_request(1'b0, 1'b1);

        // Zero everywhere: phase held at zero, one channel, loop of full range.
        apply_setting(0, 0, 0, 0, FMT_U8, 1'b0, 0);
        push_request(1'b1, 1'b0);
        repeat (3) push_request(1'b0, 1'b0);

        // Loop of one byte: every byte ends the loop.
        apply_setting(1, 1, 32'hFFFF_FFFF, 1, FMT_U16, 1'b1, 1);
        repeat (3) push_request(1'b0, 1'b1);

        // Loop that ends inside a frame, big-endian signed samples.
        apply_setting(48000, 12000, 89478, 1, FMT_S16, 1'b1, 3);
        repeat (5) push_request(1'b0, 1'b0);

        // Lower the rate without a restart so the phase sits above it.
        apply_setting(7, 5, 613566757, 1, FMT_U8, 1'b0, 200);
        repeat (3) push_request(1'b0, 1'b0);

        // Random settings with mostly well-formed streams.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_setting();
            if (ph < RANDOM_PHASES / 3)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 88;
            end
            else if (ph < 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_request($urandom_range(49) == 0, $urandom_range(3) == 0);
            if (ph == RANDOM_PHASES - 2)
                hold_requests++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("sine_test_tone_byte_stream_top_tb passed");
        else
            $display("sine_test_tone_byte_stream_top_tb failed");
        $finish;
    end

endmodule
